// ===== rtl/core/smes_pkg.sv =====
// ----------------------------------------------------------------------------
// smes_pkg
// Types, codes and constants shared by the sparse matrix entry store.
// ----------------------------------------------------------------------------
package smes_pkg;

	localparam int CAPACITY   = 256;
	localparam int ADDR_BITS  = $clog2(CAPACITY);
	localparam int CNT_BITS   = $clog2(CAPACITY + 1);
	localparam int INDEX_BITS = 16;
	localparam int DIM_BITS   = 15;
	localparam int VALUE_BITS = 32;
	localparam int ENTRY_BITS = 2 * INDEX_BITS + VALUE_BITS;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_REPLACED = 3'd1;
	localparam logic [2:0] ST_REMOVED  = 3'd2;
	localparam logic [2:0] ST_ABSENT   = 3'd3;
	localparam logic [2:0] ST_UNINIT   = 3'd4;
	localparam logic [2:0] ST_BOUND    = 3'd5;
	localparam logic [2:0] ST_NEGATIVE = 3'd6;
	localparam logic [2:0] ST_FULL     = 3'd7;

	localparam logic [1:0] OP_NONE    = 2'd0;
	localparam logic [1:0] OP_INSERT  = 2'd1;
	localparam logic [1:0] OP_REPLACE = 2'd2;
	localparam logic [1:0] OP_REMOVE  = 2'd3;

	localparam logic [1:0] RA_IDX  = 2'd0;
	localparam logic [1:0] RA_NEXT = 2'd1;
	localparam logic [1:0] RA_PREV = 2'd2;

	localparam logic CFG_NUM_ROWS = 1'b0;
	localparam logic CFG_NUM_COLS = 1'b1;

	typedef struct packed {
		logic signed [INDEX_BITS-1:0] row_index;
		logic signed [INDEX_BITS-1:0] col_index;
		logic signed [VALUE_BITS-1:0] entry_value;
	} item_t;

	typedef struct packed {
		logic [2:0]          status;
		logic [CNT_BITS-1:0] position;
		logic [CNT_BITS-1:0] entry_count;
	} result_t;

	typedef struct packed {
		logic       load;
		logic       scan_inc;
		logic       found;
		logic       found_eq;
		logic       decide;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       wr_shift;
		logic       wr_new;
		logic       idx_inc;
		logic       idx_dec;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic       scan_end;
		logic       key_less;
		logic       key_eq;
		logic [1:0] op;
		logic       dn_end;
		logic       up_end;
		logic       out_free;
	} stat_t;

endpackage

// ===== rtl/core/sparse_matrix_entry_store.sv =====
// ----------------------------------------------------------------------------
// sparse_matrix_entry_store
// Sorted row-major table of sparse matrix entries with set and remove.
// ----------------------------------------------------------------------------
//  channel | signals                          | accepted when
//  in      | in_valid, in_stall, in_data      | in_valid && !in_stall
//  out     | out_valid, out_stall, out_data   | out_valid && !out_stall
//  cfg     | cfg_we, cfg_index, cfg_data      | cfg_we
//
//  An item is located by scanning the table from the start, then decided;
//  remove shifts later entries down, insert shifts them up and writes the
//  item, replace writes it, then the result is loaded and control idles.
//  No clearing pass: the table is read only below the entry total.
//  A new item is taken while the previous result still waits; a stalled
//  result holds the next item in its final state until taken.
// ----------------------------------------------------------------------------
module sparse_matrix_entry_store
	import smes_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [DIM_BITS-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  item_t               in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output result_t             out_data
);

	cmd_t  cmd;
	stat_t st;

	smes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	smes_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/core/smes_ctrl.sv =====
// ----------------------------------------------------------------------------
// smes_ctrl
// Sequencer: scan for the sorted position, decide, shift and write the table, report.
// ----------------------------------------------------------------------------
module smes_ctrl
	import smes_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  stat_t st,
	output cmd_t  cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SCAN   = 4'd1;
	localparam logic [3:0] S_CMP    = 4'd2;
	localparam logic [3:0] S_DECIDE = 4'd3;
	localparam logic [3:0] S_DN_CHK = 4'd4;
	localparam logic [3:0] S_DN_WR  = 4'd5;
	localparam logic [3:0] S_UP_CHK = 4'd6;
	localparam logic [3:0] S_UP_WR  = 4'd7;
	localparam logic [3:0] S_WRVAL  = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (st.scan_end) begin
					cmd.found = 1'b1;
					state_d   = S_DECIDE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_IDX;
					state_d    = S_CMP;
				end
			end
			S_CMP: begin
				if (st.key_less) begin
					cmd.scan_inc = 1'b1;
					state_d      = S_SCAN;
				end else begin
					cmd.found    = 1'b1;
					cmd.found_eq = st.key_eq;
					state_d      = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				case (st.op)
					OP_REPLACE: state_d = S_WRVAL;
					OP_REMOVE:  state_d = S_DN_CHK;
					OP_INSERT:  state_d = S_UP_CHK;
					default:    state_d = S_DONE;
				endcase
			end
			S_DN_CHK: begin
				if (st.dn_end) begin
					state_d = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_NEXT;
					state_d    = S_DN_WR;
				end
			end
			S_DN_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.idx_inc  = 1'b1;
				state_d      = S_DN_CHK;
			end
			S_UP_CHK: begin
				if (st.up_end) begin
					state_d = S_WRVAL;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_PREV;
					state_d    = S_UP_WR;
				end
			end
			S_UP_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.idx_dec  = 1'b1;
				state_d      = S_UP_CHK;
			end
			S_WRVAL: begin
				cmd.wr_new = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/smes_dpath.sv =====
// ----------------------------------------------------------------------------
// smes_dpath
// Entry memory, scan and shift counters, status decision, result register.
// ----------------------------------------------------------------------------
module smes_dpath
	import smes_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [DIM_BITS-1:0] cfg_data,
	input  item_t               in_data,
	input  cmd_t                cmd,
	output stat_t               st,
	output logic                out_valid,
	input  logic                out_stall,
	output result_t             out_data
);

	logic [ENTRY_BITS-1:0] mem [CAPACITY];
	logic [ENTRY_BITS-1:0] rd_q;
	item_t                 item_q;
	logic [DIM_BITS-1:0]   rows_q;
	logic [DIM_BITS-1:0]   cols_q;
	logic [CNT_BITS-1:0]   total_q;
	logic [CNT_BITS-1:0]   idx_q;
	logic [CNT_BITS-1:0]   at_q;
	logic                  match_q;
	logic [1:0]            op_q;
	logic [2:0]            status_q;
	logic                  out_valid_q;
	result_t               out_q;

	logic [1:0]            op_d;
	logic [2:0]            status_d;
	logic [CNT_BITS-1:0]   rd_idx;
	logic signed [INDEX_BITS-1:0] e_row;
	logic signed [INDEX_BITS-1:0] e_col;
	logic                  is_bound;
	logic                  is_neg;
	logic [CNT_BITS-1:0]   total_d;
	logic [CNT_BITS-1:0]   pos_d;

	assign e_row = rd_q[ENTRY_BITS-1 -: INDEX_BITS];
	assign e_col = rd_q[VALUE_BITS +: INDEX_BITS];

	assign is_bound = (item_q.row_index >= $signed({1'b0, rows_q}))
		|| (item_q.col_index >= $signed({1'b0, cols_q}));
	assign is_neg = item_q.row_index[INDEX_BITS-1] || item_q.col_index[INDEX_BITS-1];

	always_comb begin
		op_d     = OP_NONE;
		status_d = ST_ABSENT;
		if (item_q.entry_value == '0) begin
			if (match_q) begin
				op_d     = OP_REMOVE;
				status_d = ST_REMOVED;
			end
		end else if (rows_q == '0 && cols_q == '0) begin
			status_d = ST_UNINIT;
		end else if (is_bound) begin
			status_d = ST_BOUND;
		end else if (is_neg) begin
			status_d = ST_NEGATIVE;
		end else if (match_q) begin
			op_d     = OP_REPLACE;
			status_d = ST_REPLACED;
		end else if (total_q >= CNT_BITS'(CAPACITY)) begin
			status_d = ST_FULL;
		end else begin
			op_d     = OP_INSERT;
			status_d = ST_INSERTED;
		end
	end

	always_comb begin
		st.scan_end = (idx_q >= total_q);
		st.key_less = (e_row < item_q.row_index)
			|| (e_row == item_q.row_index && e_col < item_q.col_index);
		st.key_eq   = (e_row == item_q.row_index) && (e_col == item_q.col_index);
		st.op       = op_d;
		st.dn_end   = ((idx_q + CNT_BITS'(1)) >= total_q);
		st.up_end   = (idx_q == at_q);
		st.out_free = !out_valid_q || !out_stall;
	end

	always_comb begin
		case (cmd.rd_sel)
			RA_NEXT: rd_idx = idx_q + CNT_BITS'(1);
			RA_PREV: rd_idx = idx_q - CNT_BITS'(1);
			default: rd_idx = idx_q;
		endcase
	end

	always_comb begin
		total_d = total_q;
		case (op_q)
			OP_INSERT: total_d = total_q + CNT_BITS'(1);
			OP_REMOVE: total_d = total_q - CNT_BITS'(1);
			default:   total_d = total_q;
		endcase
		if (op_q == OP_NONE) begin
			pos_d = CNT_BITS'(CAPACITY);
		end else begin
			pos_d = at_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= mem[rd_idx[ADDR_BITS-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_shift) begin
			mem[idx_q[ADDR_BITS-1:0]] <= rd_q;
		end else if (cmd.wr_new) begin
			mem[at_q[ADDR_BITS-1:0]] <= {item_q.row_index, item_q.col_index,
				item_q.entry_value};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.found) begin
			at_q    <= idx_q;
			match_q <= cmd.found_eq;
		end
		if (cmd.decide) begin
			op_q     <= op_d;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q      <= '0;
			cols_q      <= '0;
			total_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_we && cfg_index == CFG_NUM_ROWS) begin
				rows_q <= cfg_data;
			end
			if (cfg_we && cfg_index == CFG_NUM_COLS) begin
				cols_q <= cfg_data;
			end
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.scan_inc || cmd.idx_inc) begin
				idx_q <= idx_q + CNT_BITS'(1);
			end else if (cmd.idx_dec) begin
				idx_q <= idx_q - CNT_BITS'(1);
			end else if (cmd.decide) begin
				idx_q <= (op_d == OP_INSERT) ? total_q : at_q;
			end
			if (cmd.finish) begin
				total_q     <= total_d;
				out_valid_q <= 1'b1;
				out_q       <= '{status: status_q, position: pos_d, entry_count: total_d};
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_BITS'(CAPACITY))
		else $error("entry total past capacity");
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && op_q == OP_INSERT |=> total_q == $past(total_q) + CNT_BITS'(1))
		else $error("insert did not grow the table");
	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_shift |-> idx_q < CNT_BITS'(CAPACITY))
		else $error("shift write outside table");
	a_result_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && op_q != OP_NONE |-> at_q <= total_q)
		else $error("position past entry total");
`endif

endmodule
